// ===== sv/pcbp_pkg.sv =====
package pcbp_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  bit_count;
    logic [31:0] value;
    logic [31:0] bound_max;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  localparam logic [2:0] OP_RAW     = 3'd0;
  localparam logic [2:0] OP_VARINT  = 3'd1;
  localparam logic [2:0] OP_BOUNDED = 3'd2;
  localparam logic [2:0] OP_DIST    = 3'd3;
  localparam logic [2:0] OP_ERRC    = 3'd4;
  localparam logic [2:0] OP_FLUSH   = 3'd5;

  localparam int unsigned CW_W  = 36;
  localparam int unsigned ACC_W = 43;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic       err;
    logic [2:0] nbytes;
    logic       bytes_left;
  } dp_stat_t;

  function automatic logic [12:0] dist_code(input logic [7:0] i);
    logic [12:0] r;
    r = '0;
    unique case (i)
      8'd0: r = 13'd46; 8'd1: r = 13'd8; 8'd2: r = 13'd31; 8'd3: r = 13'd29;
      8'd4: r = 13'd27; 8'd5: r = 13'd24; 8'd6: r = 13'd22; 8'd7: r = 13'd19;
      8'd8: r = 13'd15; 8'd9: r = 13'd13; 8'd10: r = 13'd7; 8'd11: r = 13'd5;
      8'd12: r = 13'd1; 8'd13: r = 13'd61; 8'd14: r = 13'd56; 8'd15: r = 13'd52;
      8'd16: r = 13'd50; 8'd17: r = 13'd43; 8'd18: r = 13'd40; 8'd19: r = 13'd37;
      8'd20: r = 13'd28; 8'd21: r = 13'd24; 8'd22: r = 13'd12; 8'd23: r = 13'd5;
      8'd24: r = 13'd0; 8'd25: r = 13'd115; 8'd26: r = 13'd107; 8'd27: r = 13'd103;
      8'd28: r = 13'd95; 8'd29: r = 13'd85; 8'd30: r = 13'd82; 8'd31: r = 13'd73;
      8'd32: r = 13'd58; 8'd33: r = 13'd50; 8'd34: r = 13'd26; 8'd35: r = 13'd13;
      8'd36: r = 13'd9; 8'd37: r = 13'd242; 8'd38: r = 13'd229; 8'd39: r = 13'd212;
      8'd40: r = 13'd205; 8'd41: r = 13'd189; 8'd42: r = 13'd169; 8'd43: r = 13'd167;
      8'd44: r = 13'd145; 8'd45: r = 13'd119; 8'd46: r = 13'd103; 8'd47: r = 13'd55;
      8'd48: r = 13'd30; 8'd49: r = 13'd28; 8'd50: r = 13'd486; 8'd51: r = 13'd483;
      8'd52: r = 13'd481; 8'd53: r = 13'd480; 8'd54: r = 13'd456; 8'd55: r = 13'd427;
      8'd56: r = 13'd409; 8'd57: r = 13'd377; 8'd58: r = 13'd376; 8'd59: r = 13'd336;
      8'd60: r = 13'd332; 8'd61: r = 13'd289; 8'd62: r = 13'd237; 8'd63: r = 13'd205;
      8'd64: r = 13'd109; 8'd65: r = 13'd62; 8'd66: r = 13'd58; 8'd67: r = 13'd49;
      8'd68: r = 13'd965; 8'd69: r = 13'd964; 8'd70: r = 13'd914; 8'd71: r = 13'd852;
      8'd72: r = 13'd817; 8'd73: r = 13'd675; 8'd74: r = 13'd674; 8'd75: r = 13'd577;
      8'd76: r = 13'd472; 8'd77: r = 13'd217; 8'd78: r = 13'd100; 8'd79: r = 13'd1949;
      8'd80: r = 13'd1830; 8'd81: r = 13'd1706; 8'd82: r = 13'd946; 8'd83: r = 13'd817;
      8'd84: r = 13'd432; 8'd85: r = 13'd252; 8'd86: r = 13'd206; 8'd87: r = 13'd141;
      8'd88: r = 13'd3897; 8'd89: r = 13'd3896; 8'd90: r = 13'd3663; 8'd91: r = 13'd3662;
      8'd92: r = 13'd3415; 8'd93: r = 13'd3414; 8'd94: r = 13'd3267; 8'd95: r = 13'd3266;
      8'd96: r = 13'd3265; 8'd97: r = 13'd3264; 8'd98: r = 13'd2671; 8'd99: r = 13'd2670;
      8'd100: r = 13'd2669; 8'd101: r = 13'd2668; 8'd102: r = 13'd2667;
      8'd103: r = 13'd2666; 8'd104: r = 13'd2665; 8'd105: r = 13'd2664;
      8'd106: r = 13'd2307; 8'd107: r = 13'd2306; 8'd108: r = 13'd2305;
      8'd109: r = 13'd2304; 8'd110: r = 13'd1895; 8'd111: r = 13'd1894;
      8'd112: r = 13'd1639; 8'd113: r = 13'd1638; 8'd114: r = 13'd1637;
      8'd115: r = 13'd1636; 8'd116: r = 13'd1633; 8'd117: r = 13'd1632;
      8'd118: r = 13'd867; 8'd119: r = 13'd866; 8'd120: r = 13'd511; 8'd121: r = 13'd510;
      8'd122: r = 13'd509; 8'd123: r = 13'd508; 8'd124: r = 13'd507; 8'd125: r = 13'd506;
      8'd126: r = 13'd479; 8'd127: r = 13'd478; 8'd128: r = 13'd477; 8'd129: r = 13'd476;
      8'd130: r = 13'd475; 8'd131: r = 13'd474; 8'd132: r = 13'd473; 8'd133: r = 13'd472;
      8'd134: r = 13'd415; 8'd135: r = 13'd414; 8'd136: r = 13'd411; 8'd137: r = 13'd410;
      8'd138: r = 13'd409; 8'd139: r = 13'd408; 8'd140: r = 13'd407; 8'd141: r = 13'd406;
      8'd142: r = 13'd405; 8'd143: r = 13'd391; 8'd144: r = 13'd404; 8'd145: r = 13'd390;
      8'd146: r = 13'd389; 8'd147: r = 13'd387; 8'd148: r = 13'd388; 8'd149: r = 13'd385;
      8'd150: r = 13'd386; 8'd151: r = 13'd384; 8'd152: r = 13'd285; 8'd153: r = 13'd286;
      8'd154: r = 13'd287; 8'd155: r = 13'd281; 8'd156: r = 13'd284; 8'd157: r = 13'd278;
      8'd158: r = 13'd279; 8'd159: r = 13'd280; 8'd160: r = 13'd274; 8'd161: r = 13'd275;
      8'd162: r = 13'd276; 8'd163: r = 13'd277; 8'd164: r = 13'd269; 8'd165: r = 13'd270;
      8'd166: r = 13'd271; 8'd167: r = 13'd272; 8'd168: r = 13'd273; 8'd169: r = 13'd261;
      8'd170: r = 13'd262; 8'd171: r = 13'd263; 8'd172: r = 13'd264; 8'd173: r = 13'd265;
      8'd174: r = 13'd266; 8'd175: r = 13'd267; 8'd176: r = 13'd268;
      8'd189: r = 13'd256; 8'd190: r = 13'd257; 8'd191: r = 13'd258; 8'd192: r = 13'd259;
      8'd193: r = 13'd260;
      8'd246: r = 13'd7800; 8'd247: r = 13'd7801; 8'd248: r = 13'd7802;
      8'd249: r = 13'd7803; 8'd250: r = 13'd7804; 8'd251: r = 13'd7805;
      8'd252: r = 13'd7806; 8'd253: r = 13'd7807;
      default: begin
        if (i >= 8'd177 && i <= 8'd188) r = 13'(i - 8'd61);
        else if (i >= 8'd194 && i <= 8'd245) r = 13'(i - 8'd130);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dist_len(input logic [7:0] i);
    logic [3:0] r;
    priority if (i == 8'd0) r = 4'd6;
    else if (i == 8'd1) r = 4'd4;
    else if (i <= 8'd12) r = 4'd5;
    else if (i <= 8'd24) r = 4'd6;
    else if (i <= 8'd36) r = 4'd7;
    else if (i <= 8'd49) r = 4'd8;
    else if (i <= 8'd67) r = 4'd9;
    else if (i <= 8'd78) r = 4'd10;
    else if (i <= 8'd87) r = 4'd11;
    else if (i <= 8'd245) r = 4'd12;
    else r = 4'd13;
    return r;
  endfunction

  function automatic logic [9:0] errc_small(input logic [3:0] i);
    logic [9:0] r;
    unique case (i)
      4'd0, 4'd1, 4'd2: r = 10'd1;
      4'd3: r = 10'd0;
      4'd4: r = 10'd3;
      4'd5: r = 10'd5;
      4'd6: r = 10'd9;
      4'd7: r = 10'd17;
      4'd8: r = 10'd33;
      4'd9: r = 10'd65;
      4'd10: r = 10'd129;
      4'd11: r = 10'd257;
      4'd12: r = 10'd513;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/pcbp_ctrl.sv =====
module pcbp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pcbp_pkg::dp_stat_t stat,
  output pcbp_pkg::dp_cmd_t  cmd
);

  pcbp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      pcbp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.err) begin
            state_next = pcbp_pkg::ST_ERR;
          end else if (stat.nbytes != 3'd0) begin
            state_next = pcbp_pkg::ST_EMIT;
          end else begin
            cmd.commit = 1'b1;
          end
        end
      end
      pcbp_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit = 1'b1;
          if (!stat.bytes_left) begin
            cmd.commit = 1'b1;
            state_next = pcbp_pkg::ST_IDLE;
          end
        end
      end
      pcbp_pkg::ST_ERR: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = pcbp_pkg::ST_IDLE;
      end
      default: state_next = pcbp_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/pcbp_dp.sv =====
module pcbp_dp #(
  parameter int unsigned DIST_TABLE_DEPTH     = 254,
  parameter int unsigned ERRCOUNT_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  pcbp_pkg::in_item_t  in_item,
  input  pcbp_pkg::dp_cmd_t   cmd,
  output pcbp_pkg::dp_stat_t  stat,
  output pcbp_pkg::out_item_t out_item
);

  logic [7:0]  read_length;
  logic [6:0]  partial_bits;
  logic [2:0]  partial_count;
  logic [pcbp_pkg::ACC_W-1:0] acc;
  logic [5:0]  total;
  logic [2:0]  left;
  logic        err_item;

  logic [5:0]  n;
  logic [pcbp_pkg::CW_W-1:0] cw;
  logic [5:0]  ub_len;
  logic [pcbp_pkg::ACC_W-1:0] acc_new;
  logic [5:0]  total_new;
  logic        err_now;
  logic [31:0] v;
  logic [pcbp_pkg::CW_W-1:0] vmask;

  always_comb begin
    ub_len = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_item.bound_max[i]) ub_len = 6'(i + 1);
    end
  end

  always_comb begin
    v       = in_item.value;
    n       = '0;
    cw      = '0;
    err_now = 1'b0;
    unique case (in_item.op)
      pcbp_pkg::OP_RAW: begin
        n  = (in_item.bit_count > 6'd32) ? 6'd32 : in_item.bit_count;
        cw = {4'd0, v};
      end
      pcbp_pkg::OP_VARINT: begin
        priority if (v < 32'd16) begin
          n = 6'd5;  cw = {31'd0, 1'b0, v[3:0]};
        end else if (v < 32'd256) begin
          n = 6'd10; cw = {26'd0, 2'b10, v[7:0]};
        end else if (v < 32'd65536) begin
          n = 6'd19; cw = {17'd0, 3'b110, v[15:0]};
        end else begin
          n = 6'd35; cw = {1'b0, 3'b111, v};
        end
      end
      pcbp_pkg::OP_BOUNDED: begin
        priority if (in_item.bound_max < 32'd16) begin
          n = ub_len; cw = {4'd0, v};
        end else if (in_item.bound_max < 32'd256 && v < 32'd16) begin
          n = 6'd5;  cw = {32'd0, v[3:0]};
        end else if (in_item.bound_max >= 32'd256 && in_item.bound_max < 32'd65536
                     && v < 32'd256) begin
          n = 6'd9;  cw = {28'd0, v[7:0]};
        end else if (in_item.bound_max >= 32'd65536 && v < 32'd65536) begin
          n = 6'd17; cw = {20'd0, v[15:0]};
        end else begin
          n  = 6'(ub_len + 6'd1);
          cw = ({4'd0, v} & ((36'd1 << ub_len) - 36'd1)) | (36'd1 << ub_len);
        end
      end
      pcbp_pkg::OP_DIST: begin
        if (v < {24'd0, read_length} && v < DIST_TABLE_DEPTH && v < 32'd254) begin
          n  = {2'd0, pcbp_pkg::dist_len(v[7:0])};
          cw = {23'd0, pcbp_pkg::dist_code(v[7:0])};
        end else begin
          n = 6'd5; cw = 36'd4;
        end
      end
      pcbp_pkg::OP_ERRC: begin
        priority if (v >= ERRCOUNT_TABLE_DEPTH || v >= 32'd256) begin
          err_now = 1'b1;
        end else if (v < 32'd13) begin
          n  = 6'(v[3:0] + 4'd1);
          cw = {26'd0, pcbp_pkg::errc_small(v[3:0])};
        end else if (v < 32'd26) begin
          n = 6'd20; cw = 36'(32'd65536 + (v - 32'd13));
        end else begin
          n = 6'd21; cw = 36'(32'd131098 + (v - 32'd26));
        end
      end
      pcbp_pkg::OP_FLUSH: begin
        n = 6'd8; cw = '0;
      end
      default: n = '0;
    endcase
  end

  always_comb begin
    vmask     = (36'd1 << n) - 36'd1;
    acc_new   = ({36'd0, partial_bits} << n) | {7'd0, cw & vmask};
    total_new = 6'(partial_count) + n;
  end

  assign stat.err        = err_now;
  assign stat.nbytes     = 3'(total_new[5:3]);
  assign stat.bytes_left = (left > 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      read_length   <= 8'd100;
      partial_bits  <= '0;
      partial_count <= '0;
    end else begin
      if (cfg_we) read_length <= cfg_data;
      if (cmd.commit) begin
        if (cmd.load) begin
          partial_count <= total_new[2:0];
          partial_bits  <= acc_new[6:0] & ((7'd1 << total_new[2:0]) - 7'd1);
        end else begin
          partial_count <= total[2:0];
          partial_bits  <= acc[6:0] & ((7'd1 << total[2:0]) - 7'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc      <= acc_new;
      total    <= total_new;
      left     <= 3'(total_new[5:3]);
      err_item <= err_now;
    end else if (cmd.emit) begin
      total <= total - 6'd8;
      left  <= left - 3'd1;
    end
  end

  always_comb begin
    out_item.out_byte = err_item ? 8'd0 : 8'(acc >> (total - 6'd8));
    out_item.last     = err_item || (left == 3'd1);
    out_item.error    = err_item;
  end

endmodule

// ===== sv/prefix_code_bit_packer.sv =====
// Prefix-code bit packer.
// Input channel in_valid/in_stall carries one coding request (in_item). Each
// request appends one codeword (raw field, varint, bounded integer, distance
// code, error-count code, or an 8-bit zero flush) to an MSB-first bit stream.
// Output channel out_valid/out_stall carries one beat per completed byte;
// last marks the final byte of a request, error marks the single beat of an
// error-count request that is out of codebook range.
// A request is taken and coded in the same cycle; its beats then go out one
// per cycle while the receiver does not stall, up to five bytes for a request.
// A request that yields no beat is committed as it is taken. The output byte
// shifter serves one request at a time and takes no new one until it is done.
// Bits short of a byte stay pending between requests.
// Reset clears the pending bits and sets read_length to 100.
// While the receiver stalls, the current beat holds and no new request is
// taken. cfg_we writes read_length; write it only while idle.
module prefix_code_bit_packer #(
  parameter int unsigned DIST_TABLE_DEPTH     = 254,
  parameter int unsigned ERRCOUNT_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcbp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pcbp_pkg::out_item_t out_item
);

  pcbp_pkg::dp_cmd_t  cmd;
  pcbp_pkg::dp_stat_t stat;

  pcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcbp_dp #(
    .DIST_TABLE_DEPTH     (DIST_TABLE_DEPTH),
    .ERRCOUNT_TABLE_DEPTH (ERRCOUNT_TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
